// File: design/tnt_pkg.sv
// shared types and constants for the triangle normal and tangent block
`default_nettype none

package tnt_pkg;

	// result scale and normalization widths
	localparam int OUT_FRAC_BITS = 14;
	localparam int OUT_W         = 16;
	localparam int MAG_W         = 30;
	localparam int QUO_W         = OUT_FRAC_BITS + 1;
	localparam int QIDX_W        = $clog2(QUO_W);
	localparam int NUM_W         = MAG_W + 1 + OUT_FRAC_BITS;

	typedef logic signed [31:0]      coord_t;
	typedef logic signed [32:0]      diff_t;
	typedef logic signed [OUT_W-1:0] unit_t;

	// one vertex request
	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		coord_t tex_u;
		coord_t tex_v;
	} vertex_t;

	// one face result
	typedef struct packed {
		unit_t normal_x;
		unit_t normal_y;
		unit_t normal_z;
		unit_t tangent_x;
		unit_t tangent_y;
		unit_t tangent_z;
		logic  normal_degenerate;
		logic  tangent_degenerate;
	} result_t;

	// edge and uv differences of one face, relative to the origin vertex
	typedef struct packed {
		diff_t e1x;
		diff_t e1y;
		diff_t e1z;
		diff_t e2x;
		diff_t e2y;
		diff_t e2z;
		diff_t du1;
		diff_t dv1;
		diff_t du2;
		diff_t dv2;
	} face_t;

endpackage

`default_nettype wire

// File: design/tnt_front.sv
// front end: collects three vertices and forms the face differences
`default_nettype none

module tnt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  tnt_pkg::vertex_t vertex,
	output logic             face_push,
	input  logic             face_full,
	output tnt_pkg::face_t   face
);
	import tnt_pkg::*;

	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_THIRD  = 3'b100
	} phase_t;

	phase_t  phase_q;
	vertex_t first_q;
	vertex_t second_q;
	logic    accept;

	function automatic diff_t sub33(coord_t a, coord_t b);
		return diff_t'(a) - diff_t'(b);
	endfunction

	// request handshake
	assign full      = face_full;
	assign accept    = push & ~face_full;
	assign face_push = accept && (phase_q == PH_THIRD);

	// vertex phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
		end else if (accept) begin
			case (phase_q)
				PH_FIRST:  phase_q <= PH_SECOND;
				PH_SECOND: phase_q <= PH_THIRD;
				PH_THIRD:  phase_q <= PH_FIRST;
				default:   phase_q <= PH_FIRST;
			endcase
		end
	end

	// held vertices
	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_FIRST) begin
			first_q <= vertex;
		end
		if (accept && phase_q == PH_SECOND) begin
			second_q <= vertex;
		end
	end

	// differences against the current vertex, which is the origin
	always_comb begin
		face.e1x = sub33(second_q.pos_x, vertex.pos_x);
		face.e1y = sub33(second_q.pos_y, vertex.pos_y);
		face.e1z = sub33(second_q.pos_z, vertex.pos_z);
		face.e2x = sub33(first_q.pos_x, vertex.pos_x);
		face.e2y = sub33(first_q.pos_y, vertex.pos_y);
		face.e2z = sub33(first_q.pos_z, vertex.pos_z);
		face.du1 = sub33(second_q.tex_u, vertex.tex_u);
		face.dv1 = sub33(second_q.tex_v, vertex.tex_v);
		face.du2 = sub33(first_q.tex_u, vertex.tex_u);
		face.dv2 = sub33(first_q.tex_v, vertex.tex_v);
	end

endmodule

`default_nettype wire

// File: design/tnt_fifo.sv
// short face queue between front and back end
`default_nettype none

module tnt_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tnt_pkg::face_t din,
	output logic           full,
	input  logic           pop,
	output tnt_pkg::face_t dout,
	output logic           empty
);
	import tnt_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	face_t            entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

// File: design/tnt_back.sv
// back end: products, determinant sign and two normalizations per face
`default_nettype none

module tnt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tnt_pkg::face_t   face,
	input  logic             face_empty,
	output logic             face_pop,
	output tnt_pkg::result_t result,
	output logic             empty,
	input  logic             pop
);
	import tnt_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_FIT    = 12'b0000_0000_0010,
		S_MUL    = 12'b0000_0000_0100,
		S_ACC    = 12'b0000_0000_1000,
		S_NINIT  = 12'b0000_0001_0000,
		S_NSHIFT = 12'b0000_0010_0000,
		S_SQMUL  = 12'b0000_0100_0000,
		S_SQACC  = 12'b0000_1000_0000,
		S_SQRT   = 12'b0001_0000_0000,
		S_DINIT  = 12'b0010_0000_0000,
		S_DIV    = 12'b0100_0000_0000,
		S_DONE   = 12'b1000_0000_0000
	} state_t;

	// product schedule, pairs of terms a*b - c*d
	localparam logic [3:0] ST_DET_A = 4'd0;
	localparam logic [3:0] ST_DET_B = 4'd1;
	localparam logic [3:0] ST_NX_A  = 4'd2;
	localparam logic [3:0] ST_NX_B  = 4'd3;
	localparam logic [3:0] ST_NY_A  = 4'd4;
	localparam logic [3:0] ST_NY_B  = 4'd5;
	localparam logic [3:0] ST_NZ_A  = 4'd6;
	localparam logic [3:0] ST_NZ_B  = 4'd7;
	localparam logic [3:0] ST_TX_A  = 4'd8;
	localparam logic [3:0] ST_TX_B  = 4'd9;
	localparam logic [3:0] ST_TY_A  = 4'd10;
	localparam logic [3:0] ST_TY_B  = 4'd11;
	localparam logic [3:0] ST_TZ_A  = 4'd12;
	localparam logic [3:0] ST_TZ_B  = 4'd13;

	localparam logic       VEC_NORMAL  = 1'b0;
	localparam logic       VEC_TANGENT = 1'b1;
	localparam int         COARSE      = 8;
	localparam logic [63:0] LIM_HI     = 64'(1) << MAG_W;
	localparam logic [63:0] LIM_LO     = 64'(1) << (MAG_W - 1);
	localparam logic [63:0] LIM_HI_C   = 64'(1) << (MAG_W + COARSE - 1);
	localparam logic [63:0] LIM_LO_C   = 64'(1) << (MAG_W - 1 - COARSE);

	state_t              state_q, state_d;
	logic [3:0]          step_q, step_d;
	logic [1:0]          comp_q, comp_d;
	logic [QIDX_W-1:0]   it_q, it_d;
	logic                vsel_q, vsel_d;
	logic                outv_q, outv_d;

	diff_t               e_q [6];
	diff_t               du1_q, du2_q, dv1_q, dv2_q;
	diff_t               tv_q [2];
	logic signed [65:0]  prod_q, acc_q;
	logic                ds_neg_q, ds_zero_q;
	logic signed [63:0]  cr_q [3];
	logic signed [63:0]  tg_q [3];
	logic [63:0]         m_q [3];
	logic                neg_q [3];
	logic [63:0]         sum_q, res_q, bit_q;
	logic [NUM_W-1:0]    num_q;
	logic [QUO_W-1:0]    quo_q;
	unit_t               nrm_q [3];
	unit_t               tan_q [3];
	logic                ndeg_q, tdeg_q;
	result_t             out_q;

	logic                big_e, big_t;
	diff_t               opa, opb;
	logic signed [65:0]  prod_c, acc_diff;
	logic signed [63:0]  vec [3];
	logic [63:0]         vmag [3];
	logic                vdeg;
	logic [63:0]         mx, msel;
	logic [63:0]         sq_trial;
	logic [MAG_W:0]      len;
	logic [NUM_W-1:0]    dtrial;
	logic                dfit;
	logic [QUO_W-1:0]    q_next;
	logic [63:0]         q_wide, u_wide;
	logic                nsel;
	logic                out_load;

	function automatic diff_t halve(diff_t x, logic en);
		diff_t m;
		m = x[32] ? -x : x;
		if (en) begin
			m = m >>> 1;
		end
		return x[32] ? -m : m;
	endfunction

	function automatic logic big31(diff_t x);
		diff_t m;
		m = x[32] ? -x : x;
		return m[32] | m[31];
	endfunction

	// fit tests, one shared by the edges and one by the v differences
	assign big_e = big31(e_q[0]) | big31(e_q[1]) | big31(e_q[2]) |
		big31(e_q[3]) | big31(e_q[4]) | big31(e_q[5]);
	assign big_t = big31(dv1_q) | big31(dv2_q);

	// component magnitude selected for squaring and division
	always_comb begin
		case (comp_q)
			2'd0:    msel = m_q[0];
			2'd1:    msel = m_q[1];
			default: msel = m_q[2];
		endcase
	end

	// multiplier operand selection
	always_comb begin
		opa = '0;
		opb = '0;
		if (state_q == S_SQMUL) begin
			opa = diff_t'({1'b0, msel[MAG_W-1:0]});
			opb = diff_t'({1'b0, msel[MAG_W-1:0]});
		end else begin
			case (step_q)
				ST_DET_A: begin opa = du1_q;   opb = dv2_q;   end
				ST_DET_B: begin opa = du2_q;   opb = dv1_q;   end
				ST_NX_A:  begin opa = e_q[1];  opb = e_q[5];  end
				ST_NX_B:  begin opa = e_q[2];  opb = e_q[4];  end
				ST_NY_A:  begin opa = e_q[2];  opb = e_q[3];  end
				ST_NY_B:  begin opa = e_q[0];  opb = e_q[5];  end
				ST_NZ_A:  begin opa = e_q[0];  opb = e_q[4];  end
				ST_NZ_B:  begin opa = e_q[1];  opb = e_q[3];  end
				ST_TX_A:  begin opa = tv_q[1]; opb = e_q[0];  end
				ST_TX_B:  begin opa = tv_q[0]; opb = e_q[3];  end
				ST_TY_A:  begin opa = tv_q[1]; opb = e_q[1];  end
				ST_TY_B:  begin opa = tv_q[0]; opb = e_q[4];  end
				ST_TZ_A:  begin opa = tv_q[1]; opb = e_q[2];  end
				ST_TZ_B:  begin opa = tv_q[0]; opb = e_q[5];  end
				default:  begin opa = '0;      opb = '0;      end
			endcase
		end
	end

	assign prod_c   = opa * opb;
	assign acc_diff = acc_q - prod_q;

	// vector under normalization and its magnitudes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vec[i]  = (vsel_q == VEC_TANGENT) ? tg_q[i] : cr_q[i];
			vmag[i] = vec[i][63] ? 64'(-vec[i]) : 64'(vec[i]);
		end
		vdeg = ((vmag[0] | vmag[1] | vmag[2]) == '0) ||
			((vsel_q == VEC_TANGENT) && ds_zero_q);
	end

	// largest magnitude
	always_comb begin
		mx = m_q[0];
		if (m_q[1] > mx) begin
			mx = m_q[1];
		end
		if (m_q[2] > mx) begin
			mx = m_q[2];
		end
	end

	// square root and division trial terms
	assign sq_trial = res_q + bit_q;
	assign len      = res_q[MAG_W:0];
	assign dtrial   = NUM_W'(len) << it_q;
	assign dfit     = (num_q >= dtrial);
	assign q_next   = dfit ? (quo_q | (QUO_W'(1) << it_q)) : quo_q;
	assign q_wide   = 64'(q_next);
	assign nsel     = neg_q[comp_q == 2'd0 ? 0 : (comp_q == 2'd1 ? 1 : 2)];
	assign u_wide   = nsel ? (64'd0 - q_wide) : q_wide;
	assign out_load = (state_q == S_DONE) && (!outv_q || pop);

	// sequencer next state
	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		comp_d   = comp_q;
		it_d     = it_q;
		vsel_d   = vsel_q;
		face_pop = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (!face_empty) begin
					face_pop = 1'b1;
					state_d  = S_FIT;
				end
			end
			S_FIT: begin
				step_d  = ST_DET_A;
				state_d = S_MUL;
			end
			S_MUL: begin
				state_d = S_ACC;
			end
			S_ACC: begin
				step_d = step_q + 1'b1;
				if (step_q == ST_TZ_B) begin
					vsel_d  = VEC_NORMAL;
					state_d = S_NINIT;
				end else begin
					state_d = S_MUL;
				end
			end
			S_NINIT: begin
				if (vdeg) begin
					if (vsel_q == VEC_TANGENT) begin
						state_d = S_DONE;
					end else begin
						vsel_d = VEC_TANGENT;
					end
				end else begin
					state_d = S_NSHIFT;
				end
			end
			S_NSHIFT: begin
				if (mx < LIM_HI && mx >= LIM_LO) begin
					comp_d  = 2'd0;
					state_d = S_SQMUL;
				end
			end
			S_SQMUL: begin
				state_d = S_SQACC;
			end
			S_SQACC: begin
				if (comp_q == 2'd2) begin
					state_d = S_SQRT;
				end else begin
					comp_d  = comp_q + 1'b1;
					state_d = S_SQMUL;
				end
			end
			S_SQRT: begin
				if (bit_q == 64'd1) begin
					comp_d  = 2'd0;
					state_d = S_DINIT;
				end
			end
			S_DINIT: begin
				it_d    = QIDX_W'(QUO_W - 1);
				state_d = S_DIV;
			end
			S_DIV: begin
				if (it_q == '0) begin
					if (comp_q == 2'd2) begin
						if (vsel_q == VEC_TANGENT) begin
							state_d = S_DONE;
						end else begin
							vsel_d  = VEC_TANGENT;
							state_d = S_NINIT;
						end
					end else begin
						comp_d  = comp_q + 1'b1;
						state_d = S_DINIT;
					end
				end else begin
					it_d = it_q - 1'b1;
				end
			end
			S_DONE: begin
				if (!outv_q || pop) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// result register valid
	always_comb begin
		outv_d = outv_q;
		if (out_load) begin
			outv_d = 1'b1;
		end else if (pop) begin
			outv_d = 1'b0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_DET_A;
			comp_q  <= 2'd0;
			it_q    <= '0;
			vsel_q  <= VEC_NORMAL;
			outv_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			comp_q  <= comp_d;
			it_q    <= it_d;
			vsel_q  <= vsel_d;
			outv_q  <= outv_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (!face_empty) begin
					e_q[0] <= face.e1x;
					e_q[1] <= face.e1y;
					e_q[2] <= face.e1z;
					e_q[3] <= face.e2x;
					e_q[4] <= face.e2y;
					e_q[5] <= face.e2z;
					du1_q  <= face.du1;
					dv1_q  <= face.dv1;
					du2_q  <= face.du2;
					dv2_q  <= face.dv2;
				end
			end
			S_FIT: begin
				for (int i = 0; i < 6; i++) begin
					e_q[i] <= halve(e_q[i], big_e);
				end
				tv_q[0] <= halve(dv1_q, big_t);
				tv_q[1] <= halve(dv2_q, big_t);
			end
			S_MUL, S_SQMUL: begin
				prod_q <= prod_c;
			end
			S_ACC: begin
				if (!step_q[0]) begin
					acc_q <= prod_q;
				end else begin
					case (step_q)
						ST_DET_B: begin
							ds_neg_q  <= acc_diff[65];
							ds_zero_q <= (acc_diff == '0);
						end
						ST_NX_B: cr_q[0] <= acc_diff[63:0];
						ST_NY_B: cr_q[1] <= acc_diff[63:0];
						ST_NZ_B: cr_q[2] <= acc_diff[63:0];
						ST_TX_B: tg_q[0] <= ds_neg_q ? -acc_diff[63:0] : acc_diff[63:0];
						ST_TY_B: tg_q[1] <= ds_neg_q ? -acc_diff[63:0] : acc_diff[63:0];
						ST_TZ_B: tg_q[2] <= ds_neg_q ? -acc_diff[63:0] : acc_diff[63:0];
						default: acc_q <= acc_q;
					endcase
				end
			end
			S_NINIT: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i]   <= vmag[i];
					neg_q[i] <= vec[i][63];
				end
				if (vsel_q == VEC_TANGENT) begin
					tdeg_q <= vdeg;
					if (vdeg) begin
						for (int i = 0; i < 3; i++) begin
							tan_q[i] <= '0;
						end
					end
				end else begin
					ndeg_q <= vdeg;
					if (vdeg) begin
						for (int i = 0; i < 3; i++) begin
							nrm_q[i] <= '0;
						end
					end
				end
			end
			S_NSHIFT: begin
				for (int i = 0; i < 3; i++) begin
					if (mx >= LIM_HI_C) begin
						m_q[i] <= m_q[i] >> COARSE;
					end else if (mx >= LIM_HI) begin
						m_q[i] <= m_q[i] >> 1;
					end else if (mx < LIM_LO_C) begin
						m_q[i] <= m_q[i] << COARSE;
					end else if (mx < LIM_LO) begin
						m_q[i] <= m_q[i] << 1;
					end
				end
			end
			S_SQACC: begin
				sum_q <= ((comp_q == 2'd0) ? 64'd0 : sum_q) + prod_q[63:0];
				res_q <= '0;
				bit_q <= 64'(1) << 62;
			end
			S_SQRT: begin
				if (sum_q >= sq_trial) begin
					sum_q <= sum_q - sq_trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DINIT: begin
				num_q <= (NUM_W'(msel[MAG_W-1:0]) << OUT_FRAC_BITS) + NUM_W'(len >> 1);
				quo_q <= '0;
			end
			S_DIV: begin
				if (dfit) begin
					num_q <= num_q - dtrial;
				end
				quo_q <= q_next;
				if (it_q == '0) begin
					if (vsel_q == VEC_TANGENT) begin
						case (comp_q)
							2'd0:    tan_q[0] <= u_wide[OUT_W-1:0];
							2'd1:    tan_q[1] <= u_wide[OUT_W-1:0];
							default: tan_q[2] <= u_wide[OUT_W-1:0];
						endcase
					end else begin
						case (comp_q)
							2'd0:    nrm_q[0] <= u_wide[OUT_W-1:0];
							2'd1:    nrm_q[1] <= u_wide[OUT_W-1:0];
							default: nrm_q[2] <= u_wide[OUT_W-1:0];
						endcase
					end
				end
			end
			S_DONE: begin
				if (out_load) begin
					out_q.normal_x           <= nrm_q[0];
					out_q.normal_y           <= nrm_q[1];
					out_q.normal_z           <= nrm_q[2];
					out_q.tangent_x          <= tan_q[0];
					out_q.tangent_y          <= tan_q[1];
					out_q.tangent_z          <= tan_q[2];
					out_q.normal_degenerate  <= ndeg_q;
					out_q.tangent_degenerate <= tdeg_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign result = out_q;
	assign empty  = ~outv_q;

endmodule

`default_nettype wire

// File: design/triangle_normal_tangent.sv
// top level: vertex queue in, face normal and tangent queue out
// throughput: vertices taken one per cycle until the two-entry face queue fills;
// the back-end sequencer works on one face at a time and takes the next one after
// loading the last result (shared 33x33 multiplier, one-bit-per-cycle square root
// and divider, run for the normal and then the tangent)
// reset: arst_n clears vertex phase, queue pointers, sequencer and result valid
`default_nettype none

module triangle_normal_tangent (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  tnt_pkg::vertex_t vertex,
	output logic             empty,
	input  logic             pop,
	output tnt_pkg::result_t result
);
	import tnt_pkg::*;

	face_t front_face;
	face_t queue_face;
	logic  face_push;
	logic  face_full;
	logic  face_pop;
	logic  face_empty;

	// vertex collection
	tnt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.vertex    (vertex),
		.face_push (face_push),
		.face_full (face_full),
		.face      (front_face)
	);

	// face queue
	tnt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (face_push),
		.din    (front_face),
		.full   (face_full),
		.pop    (face_pop),
		.dout   (queue_face),
		.empty  (face_empty)
	);

	// arithmetic back end
	tnt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.face       (queue_face),
		.face_empty (face_empty),
		.face_pop   (face_pop),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

	// a face request never goes into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		face_push |-> !face_full)
		else $error("face request pushed into full queue");

	// back end takes a face only when one is there
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		face_pop |-> !face_empty)
		else $error("face request popped from empty queue");

	// degenerate normal comes with a zero vector
	a_normal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.normal_degenerate) |->
		(result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0))
		else $error("degenerate normal not zero");

	// degenerate tangent comes with a zero vector
	a_tangent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.tangent_degenerate) |->
		(result.tangent_x == '0 && result.tangent_y == '0 && result.tangent_z == '0))
		else $error("degenerate tangent not zero");

	// unit normal x and z components stay within one
	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |->
		(result.normal_x <= 16'sd16384 && result.normal_x >= -16'sd16384 &&
		result.normal_z <= 16'sd16384 && result.normal_z >= -16'sd16384))
		else $error("normal component out of range");

endmodule

`default_nettype wire
